>>> hw/rtl/deq_pkg.sv
// types and codes shared by the double-ended queue and its checker
package deq_pkg;

  // command codes
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // input item
  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] push_value;
  } in_t;

  // result item
  typedef struct packed {
    logic signed [15:0] pop_value;
    logic [1:0]         status;
    logic [6:0]         occupancy;
  } out_t;

endpackage

>>> hw/rtl/deq_ram.sv
// generic single-port ram with registered read
module deq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write, or registered read that holds until the next read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/double_ended_queue.sv
// double-ended queue of signed 16-bit values over a circular ram
//
// Bounded double-ended queue of CAPACITY signed 16-bit values. Each command
// pushes at either end, pops from either end or reverses the order; reversal
// only flips an orientation bit. Every command gives exactly one result with
// the popped value (zero unless a pop succeeded), a status (done, empty on
// pop, full on push) and the occupancy after the command, masked to 7 bits.
// One command is in flight at a time: the memory access is issued at the
// input transfer and the single-port ram returns pop data in its registered
// read, which holds until the result is loaded into the output register. A new
// command is taken while an earlier result still waits in the output
// register, but not before the pending result has moved there.
// No clearing pass is needed after reset.
module double_ended_queue #(
  parameter int CAPACITY = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  deq_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_stall,
  output deq_pkg::out_t out_data
);

  import deq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  logic          pend_r;
  logic          pend_pop_r;
  logic [1:0]    pend_status_r;
  logic [6:0]    pend_occ_r;
  logic          out_valid_r;
  out_t          out_data_r;

  logic          in_xfer;
  logic          out_load;
  logic          is_full;
  logic          is_empty;
  logic          phys_front;
  logic [1:0]    status_c;
  logic          pop_c;
  logic          mem_en;
  logic          mem_we;
  logic [IW-1:0] mem_addr;
  logic [15:0]   mem_rdata;

  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [SW-1:0] push_sum;
  logic [SW-1:0] pop_sum;
  logic [IW-1:0] back_push_idx;
  logic [IW-1:0] back_pop_idx;

  assign in_stall = pend_r;
  assign in_xfer  = in_valid && !pend_r;
  assign out_load = pend_r && (!out_valid_r || !out_stall);
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  // circular index arithmetic
  assign front_dec = (front_r == '0) ? IW'(CAPACITY - 1) : front_r - IW'(1);
  assign front_inc = (front_r == IW'(CAPACITY - 1)) ? '0 : front_r + IW'(1);
  assign push_sum  = SW'(front_r) + SW'(count_r);
  assign pop_sum   = SW'(front_r) + SW'(count_r) - SW'(1);
  assign back_push_idx = (push_sum >= SW'(CAPACITY)) ?
                         IW'(push_sum - SW'(CAPACITY)) : IW'(push_sum);
  assign back_pop_idx  = (pop_sum >= SW'(CAPACITY)) ?
                         IW'(pop_sum - SW'(CAPACITY)) : IW'(pop_sum);

  // command decode, memory access and pointer update
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    status_c   = ST_DONE;
    pop_c      = 1'b0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = front_r;
    phys_front = 1'b0;
    if (in_xfer) begin
      case (in_data.command)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          phys_front = (in_data.command == CMD_PUSH_FRONT) ^ rev_r;
          if (is_full) begin
            status_c = ST_FULL;
          end else begin
            mem_en    = 1'b1;
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
            if (phys_front) begin
              front_nxt = front_dec;
              mem_addr  = front_dec;
            end else begin
              mem_addr  = back_push_idx;
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          phys_front = (in_data.command == CMD_POP_FRONT) ^ rev_r;
          if (is_empty) begin
            status_c = ST_EMPTY;
          end else begin
            mem_en    = 1'b1;
            pop_c     = 1'b1;
            count_nxt = count_r - CW'(1);
            if (phys_front) begin
              front_nxt = front_inc;
              mem_addr  = front_r;
            end else begin
              mem_addr  = back_pop_idx;
            end
          end
        end
        CMD_REVERSE: begin
          rev_nxt = ~rev_r;
        end
        default: begin
        end
      endcase
    end
  end

  deq_ram #(
    .WIDTH (16),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_data.push_value),
    .rdata (mem_rdata)
  );

  // pointers, pending result and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rev_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      if (in_xfer) begin
        pend_r <= 1'b1;
      end else if (out_load) begin
        pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_xfer) begin
      pend_pop_r    <= pop_c;
      pend_status_r <= status_c;
      pend_occ_r    <= 7'(count_nxt);
    end
    if (out_load) begin
      out_data_r.pop_value <= pend_pop_r ? mem_rdata : '0;
      out_data_r.status    <= pend_status_r;
      out_data_r.occupancy <= pend_occ_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/deq_checker.sv
// port-level checks for the double-ended queue, bound to the top level
module deq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input deq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input deq_pkg::out_t out_data
);

  import deq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one command in flight: a transfer blocks the next cycle's input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in flight");

  // a new result only follows a command that was in flight
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a pending command");

  // refused or empty commands return no value
  a_status_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY || out_data.status == ST_FULL)
      |-> out_data.pop_value == '0)
    else $error("value returned with empty or full status");

  // an empty pop reports an empty store
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |-> out_data.occupancy == '0)
    else $error("empty status with non-zero occupancy");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
